FILE: hw/rtl/tasna_pkg.sv
//------------------------------------------------------------------------------
// tasna_pkg
// types, codes and reset values shared by the agent step block
//------------------------------------------------------------------------------
`default_nettype none

package tasna_pkg;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] action_0;
    logic signed [15:0] action_1;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic signed [15:0] teach_0;
    logic signed [15:0] teach_1;
    logic               teach_valid;
    logic [4:0]         neighbors_seen;
  } out_item_t;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_PLACE = 2'd2;

  localparam logic [2:0] REG_FRICTION     = 3'd0;
  localparam logic [2:0] REG_INV_MASS     = 3'd1;
  localparam logic [2:0] REG_TIME_STEP    = 3'd2;
  localparam logic [2:0] REG_SIGHT_RANGE  = 3'd3;
  localparam logic [2:0] REG_VISION_COUNT = 3'd4;

  localparam logic [15:0] FRICTION_RST     = 16'd6144;
  localparam logic [15:0] INV_MASS_RST     = 16'd2560;
  localparam logic [15:0] TIME_STEP_RST    = 16'd655;
  localparam logic [14:0] SIGHT_RANGE_RST  = 15'd4915;
  localparam logic [4:0]  VISION_COUNT_RST = 5'd0;

  localparam int DIV_BITS = 20;

  typedef enum logic [3:0] {
    S_IDLE, S_DRAG, S_MUL1, S_MUL2, S_MUL3, S_VEL, S_POSM, S_POS,
    S_DIST, S_SCAN, S_FETCH, S_ACC, S_PREP, S_DIV, S_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/torus_agent_step_nearest_average.sv
//------------------------------------------------------------------------------
// torus_agent_step_nearest_average
// agent on a cyclic square: motor step with friction, neighbour range count
// and nearest neighbour action average
//------------------------------------------------------------------------------
// load and place transactions complete in the idle state; op 3 is dropped
// step: motion math for each axis, a distance pass over the stored
// neighbours, then per averaged neighbour a nearest search over the distance
// ram through its single read port, a serial divide and the result strobe
// synchronous reset restores register defaults, empties the store and clears
// position and speed; no clearing pass
//------------------------------------------------------------------------------
`default_nettype none

module torus_agent_step_nearest_average #(
  parameter int MAX_NEIGHBORS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire tasna_pkg::in_item_t  item,
  output logic                      done,
  output tasna_pkg::out_item_t      result,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  import tasna_pkg::*;

  localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CW = $clog2(MAX_NEIGHBORS + 1);
  localparam int VW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_NEIGHBORS);

  state_t state, state_next;

  logic [15:0] friction, inv_mass, time_step;
  logic [14:0] sight_range;
  logic [4:0]  vision_count;

  logic [CW-1:0]      nb_count;
  logic signed [15:0] own_x, own_y, vel_x, vel_y, act0, act1;
  logic               ax;
  logic signed [33:0] d_r;
  logic [47:0]        p1;
  logic [39:0]        lo, hi;
  logic signed [32:0] q_r;
  logic [29:0]        lim;
  logic [CW-1:0]      ri, seen;
  logic               v1, v2, found;
  logic [IW-1:0]      i1, i2, best;
  logic [31:0]        dx2, dy2, best_d;
  logic [4:0]         n_r, k, r0, r1, dc;
  logic [MAX_NEIGHBORS-1:0] used;
  logic signed [19:0] s0, s1;
  logic [19:0]        a0q, a1q;
  logic               neg0, neg1;
  out_item_t          res;

  // apb
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_FRICTION:     prdata = {16'd0, friction};
      REG_INV_MASS:     prdata = {16'd0, inv_mass};
      REG_TIME_STEP:    prdata = {16'd0, time_step};
      REG_SIGHT_RANGE:  prdata = {17'd0, sight_range};
      REG_VISION_COUNT: prdata = {27'd0, vision_count};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      friction     <= FRICTION_RST;
      inv_mass     <= INV_MASS_RST;
      time_step    <= TIME_STEP_RST;
      sight_range  <= SIGHT_RANGE_RST;
      vision_count <= VISION_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRICTION:     friction     <= pwdata[15:0];
        REG_INV_MASS:     inv_mass     <= pwdata[15:0];
        REG_TIME_STEP:    time_step    <= pwdata[15:0];
        REG_SIGHT_RANGE:  sight_range  <= pwdata[14:0];
        REG_VISION_COUNT: vision_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic accept, load_we;
  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign load_we = accept && (item.operation == OP_LOAD) && (nb_count < MAX_CNT);
  assign done    = (state == S_OUT);
  assign result  = res;

  // memories
  logic [IW-1:0] e_raddr, d_raddr;
  logic [63:0]   e_rdata;
  logic [32:0]   d_rdata, d_wdata;
  logic          d_we;

  assign e_raddr = (state == S_DIST) ? ri[IW-1:0] : best;
  assign d_raddr = ri[IW-1:0];

  tasna_ram #(.WIDTH(64), .DEPTH(MAX_NEIGHBORS)) u_entry (
    .clk   (clk),
    .we    (load_we),
    .waddr (nb_count[IW-1:0]),
    .wdata ({item.pos_x, item.pos_y, item.action_0, item.action_1}),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  tasna_ram #(.WIDTH(33), .DEPTH(MAX_NEIGHBORS)) u_dist (
    .clk   (clk),
    .we    (d_we),
    .waddr (i2),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  // motion datapath
  logic signed [15:0] v_cur, f_cur, p_cur;
  logic signed [32:0] prod, q_next;
  logic signed [33:0] d_next;
  logic [31:0]        m;
  logic [47:0]        p1_next;
  logic [39:0]        lo_next, hi_next;
  logic [64:0]        rnd;
  logic [28:0]        r;
  logic signed [31:0] nv_w;
  logic signed [15:0] nv_sat;
  logic [32:0]        qm, dpm;
  logic [15:0]        pos_new;

  assign v_cur = ax ? vel_y : vel_x;
  assign f_cur = ax ? act1 : act0;
  assign p_cur = ax ? own_y : own_x;
  assign prod    = v_cur * $signed({1'b0, friction});
  assign d_next  = (34'(f_cur) <<< 10) - 34'(prod);
  assign m       = d_r[33] ? 32'(-d_r) : 32'(d_r);
  assign p1_next = m * inv_mass;
  assign lo_next = p1[23:0] * time_step;
  assign hi_next = p1[47:24] * time_step;
  assign rnd     = {1'b0, hi, 24'd0} + 65'(lo) + (65'd1 << 35);
  assign r       = rnd[64:36];
  assign nv_w    = d_r[33] ? 32'(v_cur) - 32'({3'd0, r}) : 32'(v_cur) + 32'({3'd0, r});
  assign nv_sat  = (nv_w > 32'sd32767) ? 16'sh7FFF :
                   (nv_w < -32'sd32768) ? 16'sh8000 : nv_w[15:0];
  assign q_next  = v_cur * $signed({1'b0, time_step});
  assign qm      = q_r[32] ? 33'(-q_r) : 33'(q_r);
  assign dpm     = qm + 33'd4096;
  assign pos_new = q_r[32] ? 16'(p_cur) - dpm[28:13] : 16'(p_cur) + dpm[28:13];

  // distance datapath
  logic signed [15:0] dx, dy;
  logic signed [31:0] dx_sq, dy_sq;
  logic [31:0]        d2;
  logic               inr, issue, take;
  logic [VW-1:0]      seen_w, vc_w;
  logic [4:0]         nsel;

  assign dx      = own_x - e_rdata[63:48];
  assign dy      = own_y - e_rdata[47:32];
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;
  assign d2      = dx2 + dy2;
  assign inr     = d2 < {2'd0, lim};
  assign d_wdata = {inr, d2};
  assign d_we    = (state == S_DIST) && v2;
  assign issue   = (ri < nb_count);
  assign take    = d_rdata[32] && !used[i1] && (!found || d_rdata[31:0] < best_d);
  assign seen_w  = VW'(seen);
  assign vc_w    = VW'(vision_count);
  assign nsel    = (seen == '0 || vision_count == 5'd0) ? 5'd0 :
                   (vc_w < seen_w) ? vision_count : seen_w[4:0];

  // divider
  logic [5:0]  t0, t1;
  logic        ge0, ge1;
  logic [19:0] q0, q1, mg0, mg1;
  assign t0  = {r0, a0q[19]};
  assign t1  = {r1, a1q[19]};
  assign ge0 = t0 >= {1'b0, n_r};
  assign ge1 = t1 >= {1'b0, n_r};
  assign q0  = {a0q[18:0], ge0};
  assign q1  = {a1q[18:0], ge1};
  assign mg0 = s0[19] ? 20'(-s0) : 20'(s0);
  assign mg1 = s1[19] ? 20'(-s1) : 20'(s1);

  // control
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && item.operation == OP_STEP) state_next = S_DRAG;
      S_DRAG:  state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_MUL3;
      S_MUL3:  state_next = S_VEL;
      S_VEL:   state_next = S_POSM;
      S_POSM:  state_next = S_POS;
      S_POS:   state_next = ax ? S_DIST : S_DRAG;
      S_DIST:  if (!issue && !v1 && !v2) state_next = (nsel == 5'd0) ? S_OUT : S_SCAN;
      S_SCAN:  if (!issue && !v1) state_next = S_FETCH;
      S_FETCH: state_next = S_ACC;
      S_ACC:   state_next = (k + 5'd1 == n_r) ? S_PREP : S_SCAN;
      S_PREP:  state_next = S_DIV;
      S_DIV:   if (dc == 5'(DIV_BITS - 1)) state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nb_count <= '0;
      own_x <= '0; own_y <= '0; vel_x <= '0; vel_y <= '0;
      v1 <= 1'b0; v2 <= 1'b0; found <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (accept) begin
          priority case (item.operation)
            OP_LOAD:  if (load_we) nb_count <= nb_count + 1'b1;
            OP_PLACE: begin
              own_x <= item.pos_x; own_y <= item.pos_y;
              vel_x <= '0; vel_y <= '0;
            end
            OP_STEP: begin
              act0 <= item.action_0; act1 <= item.action_1;
              ax <= 1'b0; seen <= '0;
              lim <= sight_range * sight_range;
            end
            default: ;
          endcase
        end
        S_DRAG: d_r <= d_next;
        S_MUL1: p1 <= p1_next;
        S_MUL2: lo <= lo_next;
        S_MUL3: hi <= hi_next;
        S_VEL:  if (ax) vel_y <= nv_sat; else vel_x <= nv_sat;
        S_POSM: q_r <= q_next;
        S_POS: begin
          if (ax) own_y <= pos_new; else own_x <= pos_new;
          ax <= 1'b1;
          ri <= '0; v1 <= 1'b0; v2 <= 1'b0;
        end
        S_DIST: begin
          v1 <= issue; i1 <= ri[IW-1:0];
          if (issue) ri <= ri + 1'b1;
          v2 <= v1; i2 <= i1;
          dx2 <= 32'(dx_sq); dy2 <= 32'(dy_sq);
          if (v2 && inr) seen <= seen + 1'b1;
          if (!issue && !v1 && !v2) begin
            n_r <= nsel; k <= '0; ri <= '0; found <= 1'b0; used <= '0;
            s0 <= '0; s1 <= '0;
            res.speed_x <= vel_x; res.speed_y <= vel_y;
            res.new_x <= own_x; res.new_y <= own_y;
            res.teach_0 <= '0; res.teach_1 <= '0; res.teach_valid <= 1'b0;
            res.neighbors_seen <= 5'(seen);
          end
        end
        S_SCAN: begin
          v1 <= issue; i1 <= ri[IW-1:0];
          if (issue) ri <= ri + 1'b1;
          if (v1 && take) begin
            best <= i1; best_d <= d_rdata[31:0]; found <= 1'b1;
          end
        end
        S_FETCH: ;
        S_ACC: begin
          s0 <= s0 + 20'($signed(e_rdata[31:16]));
          s1 <= s1 + 20'($signed(e_rdata[15:0]));
          used[best] <= 1'b1;
          k <= k + 5'd1; ri <= '0; found <= 1'b0; v1 <= 1'b0;
        end
        S_PREP: begin
          a0q <= mg0 + {16'd0, n_r[4:1]};
          a1q <= mg1 + {16'd0, n_r[4:1]};
          neg0 <= s0[19]; neg1 <= s1[19];
          r0 <= '0; r1 <= '0; dc <= '0;
        end
        S_DIV: begin
          a0q <= q0; a1q <= q1;
          r0 <= ge0 ? 5'(t0 - {1'b0, n_r}) : t0[4:0];
          r1 <= ge1 ? 5'(t1 - {1'b0, n_r}) : t1[4:0];
          dc <= dc + 5'd1;
          if (dc == 5'(DIV_BITS - 1)) begin
            res.teach_0 <= neg0 ? 16'(-q0) : q0[15:0];
            res.teach_1 <= neg1 ? 16'(-q1) : q1[15:0];
            res.teach_valid <= 1'b1;
          end
        end
        S_OUT: nb_count <= '0;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_count_max: assert property (@(posedge clk) disable iff (rst) nb_count <= MAX_CNT)
    else $error("neighbour count beyond store depth");
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && item.operation == OP_STEP) |=> busy)
    else $error("step transaction not started");
  a_out_clears: assert property (@(posedge clk) disable iff (rst) done |=> nb_count == '0)
    else $error("neighbour store not emptied after step");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/tasna_ram.sv
//------------------------------------------------------------------------------
// tasna_ram
// generic single write port ram with registered read
//------------------------------------------------------------------------------
`default_nettype none

module tasna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
//------------------------------------------------------------------------------
// testbench
// checks the agent step block: random and directed load, place and step
// transactions with register changes between phases; a local model predicts
// each step result and the monitor compares it field by field
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tasna_pkg::*;

  localparam int NB_MAX = 16;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int LIMIT_CYCLES = 5000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t item = '0;
  logic done;
  out_item_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  torus_agent_step_nearest_average u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  // model state
  logic [15:0] m_friction, m_inv_mass, m_time_step;
  logic [14:0] m_sight;
  logic [4:0] m_vision;
  logic [15:0] nbr_x[NB_MAX], nbr_y[NB_MAX], nbr_a0[NB_MAX], nbr_a1[NB_MAX];
  int nbr_count;
  logic [15:0] agent_x, agent_y;
  longint agent_vx, agent_vy;

  in_item_t pending_items[$];
  out_item_t expected_steps[$];
  int failures = 0;
  longint cycle_count = 0;
  int gap_left = 0;
  logic pause_req = 1'b0;
  logic reg_req = 1'b0;
  logic [4:0] reg_addr;
  logic [31:0] reg_data;
  logic reg_ack = 1'b0;
  int reg_phase = 0;

  function automatic void queue_item(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic longint round_shift(longint unsigned mag, int s, bit neg);
    longint unsigned r;
    r = (mag + (64'd1 << (s - 1))) >> s;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint integrate_axis(longint v, longint cmd,
                                            inout logic [15:0] pos);
    longint d, nv, q;
    longint unsigned m;
    bit neg;
    d = cmd * 1024 - v * longint'(m_friction);
    neg = d < 0;
    m = neg ? -d : d;
    // product can pass 2^63, kept unsigned
    m = m * 64'(m_inv_mass) * 64'(m_time_step);
    nv = v + round_shift(m, 36, neg);
    if (nv > 32767) nv = 32767;
    if (nv < -32768) nv = -32768;
    q = nv * longint'(m_time_step);
    neg = q < 0;
    q = neg ? -q : q;
    pos = pos + 16'(round_shift(q, 13, neg));
    return nv;
  endfunction

  function automatic longint avg_round(longint sum, int n);
    longint m;
    bit neg;
    neg = sum < 0;
    m = neg ? -sum : sum;
    m = (m + n / 2) / n;
    return neg ? -m : m;
  endfunction

  function automatic void predict_agent(in_item_t it);
    longint dist2[NB_MAX];
    bit in_range[NB_MAX], taken[NB_MAX];
    longint lim, dx, dy, s0, s1;
    int seen, n, best;
    bit found;
    out_item_t r;
    case (it.operation)
      OP_LOAD: begin
        if (nbr_count < NB_MAX) begin
          nbr_x[nbr_count] = it.pos_x;
          nbr_y[nbr_count] = it.pos_y;
          nbr_a0[nbr_count] = it.action_0;
          nbr_a1[nbr_count] = it.action_1;
          nbr_count++;
        end
      end
      OP_PLACE: begin
        agent_x = it.pos_x;
        agent_y = it.pos_y;
        agent_vx = 0;
        agent_vy = 0;
      end
      OP_STEP: begin
        agent_vx = integrate_axis(agent_vx, longint'(it.action_0), agent_x);
        agent_vy = integrate_axis(agent_vy, longint'(it.action_1), agent_y);
        lim = longint'(m_sight) * longint'(m_sight);
        seen = 0;
        for (int i = 0; i < nbr_count; i++) begin
          dx = longint'($signed(16'(agent_x - nbr_x[i])));
          dy = longint'($signed(16'(agent_y - nbr_y[i])));
          dist2[i] = dx * dx + dy * dy;
          in_range[i] = dist2[i] < lim;
          taken[i] = 1'b0;
          if (in_range[i]) seen++;
        end
        r = '0;
        if (seen > 0 && m_vision > 0) begin
          n = (int'(m_vision) < seen) ? int'(m_vision) : seen;
          s0 = 0;
          s1 = 0;
          for (int k = 0; k < n; k++) begin
            best = 0;
            found = 1'b0;
            for (int i = 0; i < nbr_count; i++) begin
              if (in_range[i] && !taken[i] && (!found || dist2[i] < dist2[best])) begin
                best = i;
                found = 1'b1;
              end
            end
            taken[best] = 1'b1;
            s0 += longint'($signed(nbr_a0[best]));
            s1 += longint'($signed(nbr_a1[best]));
          end
          r.teach_0 = 16'(avg_round(s0, n));
          r.teach_1 = 16'(avg_round(s1, n));
          r.teach_valid = 1'b1;
        end
        nbr_count = 0;
        r.speed_x = 16'(agent_vx);
        r.speed_y = 16'(agent_vy);
        r.new_x = agent_x;
        r.new_y = agent_y;
        r.neighbors_seen = 5'(seen);
        expected_steps.insert(expected_steps.size(), r);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      start <= 1'b0;
    end else if (reg_req && !reg_ack) begin
      start <= 1'b0;
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= reg_addr;
      pwdata <= reg_data;
      if (reg_phase == 0) begin
        penable <= 1'b0;
        reg_phase <= 1;
      end else if (reg_phase == 1) begin
        penable <= 1'b1;
        reg_phase <= 2;
      end else if (pready) begin
        psel <= 1'b0;
        penable <= 1'b0;
        reg_phase <= 0;
        reg_ack <= 1'b1;
      end
    end else begin
      if (!reg_req) reg_ack <= 1'b0;
      if (start && !busy) begin
        predict_agent(item);
        void'(pending_items.pop_front());
      end
      if (start && busy) begin
        // hold item until accepted
      end else if (pause_req || pending_items.size() == 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else begin
        item <= pending_items[0];
        start <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 3);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && done) begin
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        failures <= failures + 1;
      end else begin
        exp_r = expected_steps.pop_front();
        if (result.speed_x !== exp_r.speed_x || result.speed_y !== exp_r.speed_y ||
            result.new_x !== exp_r.new_x || result.new_y !== exp_r.new_y ||
            result.teach_0 !== exp_r.teach_0 || result.teach_1 !== exp_r.teach_1 ||
            result.teach_valid !== exp_r.teach_valid ||
            result.neighbors_seen !== exp_r.neighbors_seen) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, result);
          failures <= failures + 1;
        end
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                                         logic [15:0] a0, logic [15:0] a1);
    in_item_t it;
    it.operation = op;
    it.pos_x = x;
    it.pos_y = y;
    it.action_0 = a0;
    it.action_1 = a1;
    return it;
  endfunction

  function automatic logic [15:0] rand_action();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'sd16384;
    if (pick == 1) return -16'sd16384;
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  task automatic drain_all();
    wait (pending_items.size() == 0 && !start);
    wait (expected_steps.size() == 0);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    reg_addr <= 5'(idx) << 2;
    reg_data <= value;
    reg_req <= 1'b1;
    wait (reg_ack);
    @(posedge clk);
    reg_req <= 1'b0;
    wait (!reg_ack);
    case (idx)
      REG_FRICTION: m_friction = value[15:0];
      REG_INV_MASS: m_inv_mass = value[15:0];
      REG_TIME_STEP: m_time_step = value[15:0];
      REG_SIGHT_RANGE: m_sight = value[14:0];
      REG_VISION_COUNT: m_vision = value[4:0];
      default: ;
    endcase
  endtask

  // one random phase: well-formed load bursts then step, some noise
  task automatic queue_random(int count);
    int k, nloads;
    logic [15:0] cx, cy, spread;
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_item(make_item(2'($urandom_range(0, 3)), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom)));
        k++;
      end else begin
        nloads = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 10);
        cx = 16'($urandom);
        cy = 16'($urandom);
        spread = 16'($urandom_range(0, 6000));
        if ($urandom_range(0, 4) == 0)
          queue_item(make_item(OP_PLACE, cx, cy, 16'($urandom), 16'($urandom)));
        for (int i = 0; i < nloads; i++)
          queue_item(make_item(OP_LOAD,
            cx + 16'($urandom_range(0, 2 * spread)) - spread,
            cy + 16'($urandom_range(0, 2 * spread)) - spread,
            rand_action(), rand_action()));
        queue_item(make_item(OP_STEP, 16'($urandom), 16'($urandom),
                             rand_action(), rand_action()));
        k += nloads + 1;
      end
    end
  endtask

  initial begin
    m_friction = FRICTION_RST;
    m_inv_mass = INV_MASS_RST;
    m_time_step = TIME_STEP_RST;
    m_sight = SIGHT_RANGE_RST;
    m_vision = VISION_COUNT_RST;
    nbr_count = 0;
    agent_x = '0;
    agent_y = '0;
    agent_vx = 0;
    agent_vy = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: default registers, extremes, ties, full store, ignored op
    write_reg(REG_VISION_COUNT, 3);
    queue_item(make_item(OP_STEP, 0, 0, 16'sd16384, -16'sd16384));
    queue_item(make_item(OP_PLACE, 16'h7fff, 16'h8000, 0, 0));
    queue_item(make_item(OP_LOAD, 16'h7fff, 16'h8000, 16'sd16384, 16'sd16384));
    queue_item(make_item(OP_LOAD, 16'h8000, 16'h7fff, -16'sd16384, 16'sd3));
    queue_item(make_item(OP_LOAD, 16'h8000, 16'h7fff, 16'sd5, -16'sd16384));
    queue_item(make_item(OP_LOAD, 16'h0000, 16'h0000, 16'sd1, 16'sd1));
    queue_item(make_item(OP_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    queue_item(make_item(OP_STEP, 0, 0, -16'sd16384, 16'sd16384));
    for (int i = 0; i < 18; i++)
      queue_item(make_item(OP_LOAD, 16'(i), 16'(i), 16'(i * 7 - 60),
                           16'(i * 3 + 1)));
    queue_item(make_item(OP_STEP, 0, 0, 16'sd16384, 16'sd16384));
    drain_all();

    write_reg(REG_FRICTION, 0);
    write_reg(REG_INV_MASS, 65535);
    write_reg(REG_TIME_STEP, 65535);
    write_reg(REG_SIGHT_RANGE, 32767);
    write_reg(REG_VISION_COUNT, 31);
    for (int i = 0; i < 6; i++)
      queue_item(make_item(OP_STEP, 0, 0, 16'sd16384, -16'sd16384));
    queue_random(300);
    drain_all();

    write_reg(REG_FRICTION, 65535);
    write_reg(REG_INV_MASS, 0);
    write_reg(REG_TIME_STEP, 0);
    write_reg(REG_SIGHT_RANGE, 0);
    write_reg(REG_VISION_COUNT, 0);
    queue_random(200);
    drain_all();

    write_reg(REG_FRICTION, 65535);
    write_reg(REG_INV_MASS, 65535);
    write_reg(REG_TIME_STEP, 30000);
    write_reg(REG_SIGHT_RANGE, 6000);
    write_reg(REG_VISION_COUNT, 1);
    queue_random(300);
    // sender holds off until every step result is back
    wait (pending_items.size() < 150);
    pause_req <= 1'b1;
    wait (expected_steps.size() == 0 && !start);
    repeat (700) @(posedge clk);
    pause_req <= 1'b0;
    drain_all();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_FRICTION, $urandom_range(0, 65535));
      write_reg(REG_INV_MASS, $urandom_range(0, 65535));
      write_reg(REG_TIME_STEP, $urandom_range(0, 65535));
      write_reg(REG_SIGHT_RANGE, $urandom_range(0, 32767));
      write_reg(REG_VISION_COUNT, $urandom_range(0, 20));
      queue_random(275);
      drain_all();
    end

    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
